// ===== hw/rtl/scs1_pkg.sv =====
// Shared types and constants for the scancode set 1 event queue.
`timescale 1ns / 1ps
`default_nettype none

package scs1_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int CODE_W    = 7;
   localparam int MODS_W    = 8;
   localparam int PENDING_W = 7;
   localparam int DROP_W    = 32;

   // Operation codes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Scancode constants
   localparam logic [BYTE_W-1:0] PREFIX_BYTE = 8'hE0;
   localparam int                RELEASE_BIT = 7;
   localparam logic [CODE_W-1:0] KEY_LSHIFT  = 7'h2A;
   localparam logic [CODE_W-1:0] KEY_RSHIFT  = 7'h36;
   localparam logic [CODE_W-1:0] KEY_CTRL    = 7'h1D;
   localparam logic [CODE_W-1:0] KEY_ALT     = 7'h38;
   localparam logic [CODE_W-1:0] KEY_CAPS    = 7'h3A;

   // Modifier bit positions
   localparam int MOD_LSHIFT   = 0;
   localparam int MOD_RSHIFT   = 1;
   localparam int MOD_LCTRL    = 2;
   localparam int MOD_RCTRL    = 3;
   localparam int MOD_LALT     = 4;
   localparam int MOD_RALT     = 5;
   localparam int MOD_CAPSDOWN = 6;
   localparam int MOD_CAPSON   = 7;

   typedef struct packed {
      logic [BYTE_W-1:0] raw;
      logic              ext;
      logic [MODS_W-1:0] mods;
   } event_entry_type;

   localparam int ENTRY_W = $bits(event_entry_type);

   // Decoded view of one received byte
   typedef struct packed {
      logic              is_prefix;
      logic              ext;
      logic [MODS_W-1:0] mods;
   } byte_info_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/scs1_req_if.sv =====
// Request channel: scancode bytes and pop commands.
`timescale 1ns / 1ps
`default_nettype none

interface scs1_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] scan_byte;

   modport source (output valid, output opcode, output scan_byte, input ready);
   modport sink   (input valid, input opcode, input scan_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/scs1_rsp_if.sv =====
// Response channel: one result beat per request.
`timescale 1ns / 1ps
`default_nettype none

interface scs1_rsp_if;
   logic        valid;
   logic        ready;
   logic        event_valid;
   logic [7:0]  raw_code;
   logic [6:0]  key_index;
   logic        is_extended;
   logic        is_release;
   logic [7:0]  event_modifiers;
   logic [7:0]  live_modifiers;
   logic [6:0]  pending_count;
   logic [31:0] dropped_count;

   modport source (
      output valid, output event_valid, output raw_code, output key_index,
      output is_extended, output is_release, output event_modifiers,
      output live_modifiers, output pending_count, output dropped_count,
      input ready
   );
   modport sink (
      input valid, input event_valid, input raw_code, input key_index,
      input is_extended, input is_release, input event_modifiers,
      input live_modifiers, input pending_count, input dropped_count,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/scs1_event_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module scs1_event_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 17
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/scs1_mod_update.sv =====
// Decodes one scancode byte: prefix detection and modifier update.
`timescale 1ns / 1ps
`default_nettype none

module scs1_mod_update (
   input  wire logic [scs1_pkg::BYTE_W-1:0] scan_byte,
   input  wire logic                        prefix_armed,
   input  wire logic [scs1_pkg::MODS_W-1:0] mods_cur,
   output scs1_pkg::byte_info_type          info
);
   import scs1_pkg::*;

   logic [CODE_W-1:0] code;
   logic              pressed;
   logic              ext;
   logic [MODS_W-1:0] mods;

   assign code    = scan_byte[CODE_W-1:0];
   assign pressed = ~scan_byte[RELEASE_BIT];
   assign ext     = prefix_armed;

   always_comb begin
      mods = mods_cur;
      if (!ext && code == KEY_LSHIFT) begin
         mods[MOD_LSHIFT] = pressed;
      end else if (!ext && code == KEY_RSHIFT) begin
         mods[MOD_RSHIFT] = pressed;
      end else if (code == KEY_CTRL) begin
         if (ext) begin
            mods[MOD_RCTRL] = pressed;
         end else begin
            mods[MOD_LCTRL] = pressed;
         end
      end else if (code == KEY_ALT) begin
         if (ext) begin
            mods[MOD_RALT] = pressed;
         end else begin
            mods[MOD_LALT] = pressed;
         end
      end else if (!ext && code == KEY_CAPS) begin
         // caps lock toggles on the first press only, not on typematic repeats
         if (pressed) begin
            if (!mods_cur[MOD_CAPSDOWN]) begin
               mods[MOD_CAPSDOWN] = 1'b1;
               mods[MOD_CAPSON]   = ~mods_cur[MOD_CAPSON];
            end
         end else begin
            mods[MOD_CAPSDOWN] = 1'b0;
         end
      end
   end

   assign info.is_prefix = (scan_byte == PREFIX_BYTE);
   assign info.ext       = ext;
   assign info.mods      = mods;

endmodule

`default_nettype wire

// ===== hw/rtl/scancode_set1_event_queue.sv =====
// Top level of the scancode set 1 event queue.
`timescale 1ns / 1ps
`default_nettype none

// Scancode set 1 event queue.
//
// req_if (sink): one beat is either a received keyboard byte (opcode 0) or a
// pop of the oldest queued event (opcode 1). rsp_if (source): exactly one
// beat per request, carrying the popped event (or zeros), the live modifier
// bits, the queue fill and the wrapping drop counter.
//
// Events live in a QUEUE_DEPTH-entry synchronous RAM with registered read
// data. A byte beat is decoded, written (unless it is the E0 prefix, or the
// queue is full, where the drop counter counts it instead) and its response
// registered in the accept cycle, valid in the next cycle. A pop beat
// reads the RAM in the accept cycle and registers the response from the
// read data the next cycle. An empty-queue pop responds like a byte beat.
//
// One beat is in flight at a time; the block takes the next request in the
// same cycle the pending response is taken. A pop holds req_if.ready low
// in ST_READ while it waits for the RAM read data.
// While the receiver stalls, the response register holds and req_if.ready
// stays low. Reset (synchronous) empties the queue, clears the drop counter,
// the prefix flag and all modifiers; RAM contents are not cleared.
module scancode_set1_event_queue (
   input wire logic clock,
   input wire logic reset,
   scs1_req_if.sink   req_if,
   scs1_rsp_if.source rsp_if
);
   import scs1_pkg::*;

   // control state
   state_type          state_ff,     state_in;
   logic [PTR_W-1:0]   rd_ptr_ff,    rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff,    wr_ptr_in;
   logic [FILL_W-1:0]  fill_ff,      fill_in;
   logic [DROP_W-1:0]  drop_ff,      drop_in;
   logic               prefix_ff,    prefix_in;
   logic [MODS_W-1:0]  mods_ff,      mods_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // response payload register
   event_entry_type    rsp_entry_ff,   rsp_entry_in;
   logic               rsp_evalid_ff,  rsp_evalid_in;
   logic [MODS_W-1:0]  rsp_live_ff,    rsp_live_in;
   logic [FILL_W-1:0]  rsp_fill_ff,    rsp_fill_in;
   logic [DROP_W-1:0]  rsp_drop_ff,    rsp_drop_in;
   logic               rsp_load;

   // RAM port
   logic               ram_wr_en;
   event_entry_type    ram_wr_data;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;

   byte_info_type      info;
   logic               accept;
   logic               full;

   scs1_mod_update u_mod_update (
      .scan_byte    (req_if.scan_byte),
      .prefix_armed (prefix_ff),
      .mods_cur     (mods_ff),
      .info         (info)
   );

   scs1_event_ram #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (ENTRY_W)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // free to accept when idle and the response register is empty or draining
   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (fill_ff == FILL_W'(QUEUE_DEPTH));

   assign ram_wr_data.raw  = req_if.scan_byte;
   assign ram_wr_data.ext  = info.ext;
   assign ram_wr_data.mods = info.mods;

   always_comb begin
      state_in      = state_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_in       = fill_ff;
      drop_in       = drop_ff;
      prefix_in     = prefix_ff;
      mods_in       = mods_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      rsp_load      = 1'b0;
      rsp_entry_in  = '0;
      rsp_evalid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.opcode == OP_BYTE) begin
                  rsp_load = 1'b1;
                  if (info.is_prefix) begin
                     prefix_in = 1'b1;
                  end else begin
                     prefix_in = 1'b0;
                     mods_in   = info.mods;
                     if (full) begin
                        drop_in = drop_ff + 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                        wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                                    '0 : wr_ptr_ff + 1'b1;
                        fill_in   = fill_ff + 1'b1;
                     end
                  end
               end else if (fill_ff != '0) begin
                  // pop: read now, respond once the RAM data is back
                  ram_rd_en = 1'b1;
                  rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_ff + 1'b1;
                  fill_in   = fill_ff - 1'b1;
                  state_in  = ST_READ;
               end else begin
                  // pop on empty queue
                  rsp_load = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_load      = 1'b1;
            rsp_entry_in  = event_entry_type'(ram_rd_data);
            rsp_evalid_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_live_in = mods_in;
      rsp_fill_in = fill_in;
      rsp_drop_in = drop_in;

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         drop_ff      <= '0;
         prefix_ff    <= 1'b0;
         mods_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         prefix_ff    <= prefix_in;
         mods_ff      <= mods_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_entry_ff  <= rsp_entry_in;
         rsp_evalid_ff <= rsp_evalid_in;
         rsp_live_ff   <= rsp_live_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_drop_ff   <= rsp_drop_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.event_valid     = rsp_evalid_ff;
   assign rsp_if.raw_code        = rsp_entry_ff.raw;
   assign rsp_if.key_index       = rsp_entry_ff.raw[CODE_W-1:0];
   assign rsp_if.is_extended     = rsp_entry_ff.ext;
   assign rsp_if.is_release      = rsp_entry_ff.raw[RELEASE_BIT];
   assign rsp_if.event_modifiers = rsp_entry_ff.mods;
   assign rsp_if.live_modifiers  = rsp_live_ff;
   assign rsp_if.pending_count   = PENDING_W'(rsp_fill_ff);
   assign rsp_if.dropped_count   = rsp_drop_ff;

endmodule

`default_nettype wire
